// ===== hdl/rfmc_pkg.sv =====
package rfmc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned CntW  = 5;
  localparam int unsigned CfgW  = 3;

  localparam logic [CfgW-1:0] CapLog2Reset = 3'd4;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_FLUSH = 3'd3,
    CMD_COUNT = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  // result fields that travel down the output pipe
  typedef struct packed {
    status_e         status;
    logic [CntW-1:0] match;
    logic [CntW-1:0] fill;
    logic [CntW-1:0] free;
  } res_t;

endpackage

// ===== hdl/rfmc_ram.sv =====
module rfmc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ring_fifo_with_match_count_core.sv =====
// ring fifo with a match counter, built around one ram with a write port and a read port
//
// input channel (in_valid_i / in_ready_o) carries a command word: cmd_i and
// data_in_i. output channel (out_valid_o / out_ready_i) returns one result
// word per command: status, data_out, match_count, fill_level, free_space.
// cfg_we_i / cfg_wdata_i write capacity_log2; the write also clears both
// pointers, and is meant for an idle block.
//
// push, pop, peek, flush and unknown commands stream one word per cycle
// while the output is not stalled; a result is registered first in the accept
// stage (with the ram read), then in the output register.
// count matches walks the stored entries through the ram read port, one
// entry a cycle; in_ready_o stays low from the time the count is taken
// until the scan has compared every stored entry and loaded its result.
//
// reset clears the pointers and sets capacity_log2 to 4; the ram is not
// cleared, and an entry is only read after it has been pushed.
// when the receiver stalls, the output register holds its word and one more
// result waits in the accept stage; only then does in_ready_o drop.
module ring_fifo_with_match_count_core import rfmc_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CmdW-1:0]  cmd_i,
  input  logic [DataW-1:0] data_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [DataW-1:0] data_out_o,
  output logic [CntW-1:0]  match_count_o,
  output logic [CntW-1:0]  fill_level_o,
  output logic [CntW-1:0]  free_space_o
);

  // largest usable capacity is the largest power of two not above DEPTH
  localparam int unsigned MaxLog2 = $clog2(DEPTH + 1) - 1;
  localparam int unsigned PtrW    = MaxLog2 + 1;
  localparam int unsigned AddrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned StoreW  = (ITEM_WIDTH < DataW) ? ITEM_WIDTH : DataW;

  // configuration and pointers
  logic [CfgW-1:0] cap_log2_q;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;

  // scan sequencer
  state_e            state_q, state_d;
  logic [PtrW-1:0]   scan_idx_q, scan_idx_d;
  logic              scan_pend_q, scan_pend_d;
  logic [PtrW-1:0]   match_q, match_d;
  logic [StoreW-1:0] key_q, key_d;

  // accept stage and output register
  logic       s1_valid_q, s1_valid_d;
  res_t       s1_res_q, s1_res_d;
  logic       s1_use_rd_q, s1_use_rd_d;
  logic       s1_load, s1_adv;
  logic       out_valid_q;
  res_t       out_res_q;
  logic [DataW-1:0] out_data_q;

  // ram port
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [StoreW-1:0] ram_wdata, ram_rdata;

  logic [4:0]      cap_sel;
  logic [PtrW-1:0] cap, imask, fill, fill_after;
  logic            accept;

  // capacity saturates at the largest power of two the ram can hold
  assign cap_sel = (5'(cap_log2_q) > 5'(MaxLog2)) ? 5'(MaxLog2) : 5'(cap_log2_q);
  assign cap     = PtrW'(1) << cap_sel;
  assign imask   = cap - PtrW'(1);
  assign fill    = wr_ptr_q - rd_ptr_q;

  // accept stage drains into the output register when that one is free or taken
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE) && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    scan_idx_d  = scan_idx_q;
    scan_pend_d = scan_pend_q;
    match_d     = match_q;
    key_d       = key_q;
    ram_we      = 1'b0;
    ram_waddr   = AddrW'(wr_ptr_q & imask);
    ram_wdata   = data_in_i[StoreW-1:0];
    ram_re      = 1'b0;
    ram_raddr   = AddrW'(rd_ptr_q & imask);
    s1_load     = 1'b0;
    s1_use_rd_d = 1'b0;
    s1_res_d.status = STAT_OK;
    s1_res_d.match  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_PUSH: begin
              s1_load = 1'b1;
              if (fill < cap) begin
                ram_we   = 1'b1;
                wr_ptr_d = wr_ptr_q + PtrW'(1);
              end else begin
                s1_res_d.status = STAT_FULL;
              end
            end
            CMD_POP, CMD_PEEK: begin
              s1_load = 1'b1;
              if (fill != '0) begin
                ram_re      = 1'b1;
                s1_use_rd_d = 1'b1;
                if (cmd_i == CMD_POP) begin
                  rd_ptr_d = rd_ptr_q + PtrW'(1);
                end
              end else begin
                s1_res_d.status = STAT_EMPTY;
              end
            end
            CMD_FLUSH: begin
              s1_load  = 1'b1;
              rd_ptr_d = '0;
              wr_ptr_d = '0;
            end
            CMD_COUNT: begin
              state_d     = S_SCAN;
              scan_idx_d  = '0;
              scan_pend_d = 1'b0;
              match_d     = '0;
              key_d       = data_in_i[StoreW-1:0];
            end
            default: begin
              // unknown command: no change, plain success word
              s1_load = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // compare the word read last cycle
        if (scan_pend_q && (ram_rdata == key_q)) begin
          match_d = match_q + PtrW'(1);
        end
        if (scan_idx_q != fill) begin
          ram_re      = 1'b1;
          ram_raddr   = AddrW'((rd_ptr_q + scan_idx_q) & imask);
          scan_idx_d  = scan_idx_q + PtrW'(1);
          scan_pend_d = 1'b1;
        end else begin
          scan_pend_d = 1'b0;
          if (!scan_pend_q) begin
            // all compares done, accept stage is empty here
            s1_load        = 1'b1;
            s1_res_d.match = CntW'(match_q);
            state_d        = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // capacity write reinitializes the ring
    if (cfg_we_i) begin
      rd_ptr_d = '0;
      wr_ptr_d = '0;
    end

    fill_after    = wr_ptr_d - rd_ptr_d;
    s1_res_d.fill = CntW'(fill_after);
    s1_res_d.free = CntW'(cap - fill_after);
    s1_valid_d    = s1_load || (s1_valid_q && !s1_adv);
  end

  rfmc_ram #(
    .WIDTH (StoreW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_log2_q  <= CapLog2Reset;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      state_q     <= S_IDLE;
      scan_pend_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_log2_q <= cfg_wdata_i;
      end
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      state_q     <= state_d;
      scan_pend_q <= scan_pend_d;
      s1_valid_q  <= s1_valid_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    match_q    <= match_d;
    key_q      <= key_d;
    if (s1_load) begin
      s1_res_q    <= s1_res_d;
      s1_use_rd_q <= s1_use_rd_d;
    end
    if (s1_adv) begin
      out_res_q  <= s1_res_q;
      // ram read data holds until the next read, which waits for this move
      out_data_q <= s1_use_rd_q ? DataW'(ram_rdata) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_res_q.status;
  assign data_out_o    = out_data_q;
  assign match_count_o = out_res_q.match;
  assign fill_level_o  = out_res_q.fill;
  assign free_space_o  = out_res_q.free;

endmodule

// ===== hdl/rfmc_checker.sv =====
module rfmc_checker import rfmc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [1:0]       status_o,
  input logic [DataW-1:0] data_out_o,
  input logic [CntW-1:0]  match_count_o,
  input logic [CntW-1:0]  fill_level_o,
  input logic [CntW-1:0]  free_space_o
);

  // stalled result word keeps its status, data, match count and fill level
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(data_out_o) && $stable(match_count_o) && $stable(fill_level_o))
    else $error("result word changed while stalled");

  // a refused push means no room was left
  a_full_no_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_FULL |-> free_space_o == '0)
    else $error("full status with free space left");

  // a refused pop or peek means nothing stored and no data returned
  a_empty_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_EMPTY |-> fill_level_o == '0 && data_out_o == '0)
    else $error("empty status with data or fill");

  // failures never carry a match count
  a_fail_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> match_count_o == '0)
    else $error("match count on failed command");

endmodule

bind ring_fifo_with_match_count_core rfmc_checker u_rfmc_checker (.*);
